// ===== rtl/core/interval_period_estimator_core_assert.svh =====
// Assertion macros for the period estimator core; expect clk and arst_n in scope.
`ifndef INTERVAL_PERIOD_ESTIMATOR_CORE_ASSERT_SVH
`define INTERVAL_PERIOD_ESTIMATOR_CORE_ASSERT_SVH

// same-cycle implication
`define IPE_ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// next-cycle implication
`define IPE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

// ===== rtl/core/ipe_pkg.sv =====
package ipe_pkg;

	localparam int INTERVAL_W   = 24;
	localparam int TOLERANCE_W  = 16;
	localparam int MIN_START_W  = 23;
	localparam int CFG_DATA_W   = 23;
	localparam int CFG_INDEX_W  = 1;
	localparam int COUNT_OUT_W  = 7;
	localparam int SUM_W        = 32;
	localparam int RECIP_W      = 28;
	localparam int RECIP_SHIFT  = 27;
	localparam int QUEUE_DEPTH  = 4;

	localparam int NUM_INTERVALS_DEF = 16;
	localparam int MAX_DIVISOR_DEF   = 5;

	localparam logic [CFG_INDEX_W-1:0] CFG_TOLERANCE = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_MIN_START = 1'd1;

	localparam logic [TOLERANCE_W-1:0] TOLERANCE_RST = 16'd6554;
	localparam logic [MIN_START_W-1:0] MIN_START_RST = 23'd6553600;

	typedef struct packed {
		logic signed [INTERVAL_W-1:0] interval;
		logic signed [INTERVAL_W-1:0] minimum;
		logic                         wr;
		logic                         last;
	} entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

	// floor(2^27 / d) + 1: exact floor division of a 24-bit magnitude by d
	function automatic logic [RECIP_W-1:0] recip(input logic [3:0] d);
		logic [RECIP_W-1:0] r;
		case (d)
			4'd1: r = 28'd134217729;
			4'd2: r = 28'd67108865;
			4'd3: r = 28'd44739243;
			4'd4: r = 28'd33554433;
			4'd5: r = 28'd26843546;
			4'd6: r = 28'd22369622;
			4'd7: r = 28'd19173962;
			4'd8: r = 28'd16777217;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/core/ipe_front.sv =====
module ipe_front #(
	parameter int NUM_INTERVALS = ipe_pkg::NUM_INTERVALS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic signed [ipe_pkg::INTERVAL_W-1:0]  interval,
	input  logic                                   last,
	input  logic                                   item_valid,
	output logic                                   item_stall,
	input  logic [ipe_pkg::MIN_START_W-1:0]        minimum_start,
	input  ipe_pkg::qstat_t                        q_stat,
	output logic                                   q_push,
	output ipe_pkg::entry_t                        q_entry
);
	import ipe_pkg::*;

	localparam int NW = $clog2(NUM_INTERVALS + 1);

	logic [NW-1:0]                load_q;
	logic signed [INTERVAL_W-1:0] rmin_q;
	logic                         wr_c;
	logic signed [INTERVAL_W-1:0] new_min_c;

	assign wr_c = load_q < NW'(NUM_INTERVALS);

	always_comb begin
		if (load_q == '0) begin
			new_min_c = $signed({1'b0, minimum_start});
		end else if (interval < rmin_q) begin
			new_min_c = interval;
		end else begin
			new_min_c = rmin_q;
		end
	end

	assign item_stall        = q_stat.full;
	assign q_push            = item_valid && !q_stat.full;
	assign q_entry.interval  = interval;
	assign q_entry.minimum   = wr_c ? new_min_c : rmin_q;
	assign q_entry.wr        = wr_c;
	assign q_entry.last      = last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_q <= '0;
			rmin_q <= '0;
		end else if (q_push) begin
			if (last) begin
				load_q <= '0;
			end else if (wr_c) begin
				load_q <= load_q + 1'b1;
			end
			if (wr_c) begin
				rmin_q <= new_min_c;
			end
		end
	end

endmodule

// ===== rtl/core/ipe_queue.sv =====
module ipe_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  ipe_pkg::entry_t wr_entry,
	input  logic            pop,
	output ipe_pkg::entry_t rd_entry,
	output ipe_pkg::qstat_t stat
);
	import ipe_pkg::*;

	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int FW = $clog2(QUEUE_DEPTH + 1);

	entry_t        slots_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [FW-1:0] fill_q;

	assign stat.full  = fill_q == FW'(QUEUE_DEPTH);
	assign stat.empty = fill_q == '0;
	assign rd_entry   = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/core/ipe_back.sv =====
module ipe_back #(
	parameter int NUM_INTERVALS = ipe_pkg::NUM_INTERVALS_DEF,
	parameter int MAX_DIVISOR   = ipe_pkg::MAX_DIVISOR_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  ipe_pkg::entry_t                        q_entry,
	input  ipe_pkg::qstat_t                        q_stat,
	output logic                                   q_pop,
	input  logic [ipe_pkg::TOLERANCE_W-1:0]        tolerance,
	output logic signed [ipe_pkg::INTERVAL_W-1:0]  period,
	output logic [ipe_pkg::COUNT_OUT_W-1:0]        match_count,
	output logic                                   no_match,
	output logic                                   result_valid,
	input  logic                                   result_stall
);
	import ipe_pkg::*;

	localparam int AW    = $clog2(NUM_INTERVALS);
	localparam int NW    = $clog2(NUM_INTERVALS + 1);
	localparam int XW    = $clog2(MAX_DIVISOR + 1);
	localparam int MXW   = INTERVAL_W + XW;
	localparam int CNTW  = $clog2((NUM_INTERVALS - 1) * MAX_DIVISOR + 1);
	localparam int CW7   = (CNTW > COUNT_OUT_W) ? CNTW : COUNT_OUT_W;
	localparam int DSW   = $clog2(SUM_W);
	localparam int PW    = INTERVAL_W + RECIP_W;

	localparam logic signed [SUM_W:0] SatHi = 33'sd8388607;
	localparam logic signed [SUM_W:0] SatLo = -33'sd8388608;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_READ  = 3'd1;
	localparam logic [2:0] ST_PAIR  = 3'd2;
	localparam logic [2:0] ST_DRAIN = 3'd3;
	localparam logic [2:0] ST_DIV   = 3'd4;
	localparam logic [2:0] ST_DONE  = 3'd5;

	logic [2:0]                   state_q;
	logic [NW-1:0]                wcnt_q;
	logic [NW-1:0]                n_q;
	logic [NW-1:0]                i_q;
	logic [XW-1:0]                x_q;
	logic signed [INTERVAL_W-1:0] m_q;
	logic signed [MXW-1:0]        mx_q;
	logic [SUM_W-1:0]             sum_q;
	logic [CNTW-1:0]              cnt_q;
	logic [SUM_W-1:0]             dq_q;
	logic [CNTW:0]                rem_q;
	logic [DSW-1:0]               dstep_q;
	logic                         dneg_q;
	logic                         result_valid_q;
	logic signed [INTERVAL_W-1:0] period_q;
	logic [COUNT_OUT_W-1:0]       match_count_q;
	logic                         no_match_q;

	logic signed [INTERVAL_W-1:0] store_q [NUM_INTERVALS];
	logic signed [INTERVAL_W-1:0] rd_q;

	// pair test pipeline
	logic                         v_s1;
	logic [MXW:0]                 absdiff_s1;
	logic signed [MXW+16:0]       rhs_s1;
	logic [INTERVAL_W-1:0]        qmag_s1;
	logic                         qneg_s1;
	logic                         v_s2;
	logic [INTERVAL_W-1:0]        quot_s2;

	logic                         issue_c;
	logic signed [MXW-1:0]        m_ext_c;
	logic [MXW:0]                 diff_c;
	logic [MXW:0]                 absdiff_c;
	logic signed [MXW+16:0]       rhs_c;
	logic [INTERVAL_W-1:0]        vabs_c;
	logic [PW-1:0]                prod_c;
	logic signed [MXW+17:0]       lhs_cmp_c;
	logic signed [MXW+17:0]       rhs_cmp_c;
	logic                         match_c;
	logic [NW-1:0]                n_next_c;
	logic [CNTW:0]                rem_sh_c;
	logic                         ge_c;
	logic [SUM_W:0]               qmag33_c;
	logic signed [SUM_W:0]        qs_c;
	logic signed [INTERVAL_W-1:0] mean_c;
	logic [CW7-1:0]               cnt_ext_c;
	logic                         out_free_c;

	assign q_pop      = (state_q == ST_IDLE) && !q_stat.empty;
	assign issue_c    = state_q == ST_PAIR;
	assign n_next_c   = wcnt_q + NW'(q_entry.wr);
	assign out_free_c = !result_valid_q || !result_stall;

	assign m_ext_c   = {{XW{m_q[INTERVAL_W-1]}}, m_q};
	assign diff_c    = {{(XW + 1){rd_q[INTERVAL_W-1]}}, rd_q} - {mx_q[MXW-1], mx_q};
	assign absdiff_c = diff_c[MXW] ? (~diff_c + 1'b1) : diff_c;
	assign rhs_c     = $signed({1'b0, tolerance}) * mx_q;
	assign vabs_c    = rd_q[INTERVAL_W-1] ? (~rd_q + 1'b1) : rd_q;
	assign prod_c    = vabs_c * recip(4'(x_q));

	assign lhs_cmp_c = $signed({1'b0, absdiff_s1, 16'b0});
	assign rhs_cmp_c = {rhs_s1[MXW+16], rhs_s1};

	always_comb begin
		if (m_q[INTERVAL_W-1]) begin
			match_c = lhs_cmp_c > rhs_cmp_c;
		end else if (m_q != '0) begin
			match_c = lhs_cmp_c < rhs_cmp_c;
		end else begin
			match_c = 1'b0;
		end
	end

	assign rem_sh_c = {rem_q[CNTW-1:0], dq_q[SUM_W-1]};
	assign ge_c     = rem_sh_c >= {1'b0, cnt_q};

	assign qmag33_c  = {1'b0, dq_q};
	assign qs_c      = dneg_q ? $signed(~qmag33_c + 1'b1) : $signed(qmag33_c);
	assign cnt_ext_c = CW7'(cnt_q);

	always_comb begin
		if (qs_c > SatHi) begin
			mean_c = SatHi[INTERVAL_W-1:0];
		end else if (qs_c < SatLo) begin
			mean_c = SatLo[INTERVAL_W-1:0];
		end else begin
			mean_c = qs_c[INTERVAL_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && q_entry.wr) begin
			store_q[wcnt_q[AW-1:0]] <= q_entry.interval;
		end
		rd_q <= store_q[i_q[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		absdiff_s1 <= absdiff_c;
		rhs_s1     <= rhs_c;
		qmag_s1    <= prod_c[RECIP_SHIFT +: INTERVAL_W];
		qneg_s1    <= rd_q[INTERVAL_W-1];
		quot_s2    <= qneg_s1 ? (~qmag_s1 + 1'b1) : qmag_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			wcnt_q         <= '0;
			n_q            <= '0;
			i_q            <= '0;
			x_q            <= '0;
			m_q            <= '0;
			mx_q           <= '0;
			sum_q          <= '0;
			cnt_q          <= '0;
			dq_q           <= '0;
			rem_q          <= '0;
			dstep_q        <= '0;
			dneg_q         <= 1'b0;
			v_s1           <= 1'b0;
			v_s2           <= 1'b0;
			result_valid_q <= 1'b0;
			period_q       <= '0;
			match_count_q  <= '0;
			no_match_q     <= 1'b0;
		end else begin
			v_s1 <= issue_c;
			v_s2 <= v_s1 && match_c;
			if (v_s2) begin
				sum_q <= sum_q + {{(SUM_W - INTERVAL_W){quot_s2[INTERVAL_W-1]}}, quot_s2};
				cnt_q <= cnt_q + 1'b1;
			end
			if (result_valid_q && !result_stall && state_q != ST_DONE) begin
				result_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (q_pop) begin
						if (q_entry.last) begin
							wcnt_q  <= '0;
							n_q     <= n_next_c;
							m_q     <= q_entry.minimum;
							i_q     <= NW'(1);
							sum_q   <= '0;
							cnt_q   <= '0;
							state_q <= (n_next_c > NW'(1)) ? ST_READ : ST_DRAIN;
						end else if (q_entry.wr) begin
							wcnt_q <= wcnt_q + 1'b1;
						end
					end
				end
				ST_READ: begin
					x_q     <= XW'(1);
					mx_q    <= m_ext_c;
					state_q <= ST_PAIR;
				end
				ST_PAIR: begin
					if (x_q == XW'(MAX_DIVISOR)) begin
						i_q     <= i_q + 1'b1;
						state_q <= ((i_q + 1'b1) == n_q) ? ST_DRAIN : ST_READ;
					end else begin
						x_q  <= x_q + 1'b1;
						mx_q <= mx_q + m_ext_c;
					end
				end
				ST_DRAIN: begin
					if (!v_s1 && !v_s2) begin
						if (cnt_q == '0) begin
							state_q <= ST_DONE;
						end else begin
							dq_q    <= sum_q[SUM_W-1] ? (~sum_q + 1'b1) : sum_q;
							dneg_q  <= sum_q[SUM_W-1];
							rem_q   <= '0;
							dstep_q <= '0;
							state_q <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					rem_q   <= ge_c ? (rem_sh_c - {1'b0, cnt_q}) : rem_sh_c;
					dq_q    <= {dq_q[SUM_W-2:0], ge_c};
					dstep_q <= dstep_q + 1'b1;
					if (dstep_q == DSW'(SUM_W - 1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free_c) begin
						result_valid_q <= 1'b1;
						if (cnt_q == '0) begin
							period_q      <= '0;
							match_count_q <= '0;
							no_match_q    <= 1'b1;
						end else begin
							period_q      <= mean_c;
							match_count_q <= (cnt_ext_c > CW7'(127)) ? 7'd127 :
								cnt_ext_c[COUNT_OUT_W-1:0];
							no_match_q    <= 1'b0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign result_valid = result_valid_q;
	assign period       = period_q;
	assign match_count  = match_count_q;
	assign no_match     = no_match_q;

endmodule

// ===== rtl/core/interval_period_estimator_core.sv =====
// channel  dir  handshake                    payload
// item     in   item_valid / item_stall      interval, last
// result   out  result_valid / result_stall  period, match_count, no_match
// config   in   cfg_we                       cfg_index, cfg_data
//
// Plain items go from the front into the queue; the 4-deep queue
// absorbs bursts, so item_stall rises only when it is full.
// A last item with n stored intervals occupies the back for (n-1)*MAX_DIVISOR pair tests,
// one pair test per cycle within a sweep, then a 32-step serial divider if any matched.
// Reset is asynchronous and clears control state; the interval store needs no clearing.
// A result waits in the output register while result_stall is high.
`include "interval_period_estimator_core_assert.svh"

module interval_period_estimator_core #(
	parameter int NUM_INTERVALS = ipe_pkg::NUM_INTERVALS_DEF,
	parameter int MAX_DIVISOR   = ipe_pkg::MAX_DIVISOR_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   item_valid,
	output logic                                   item_stall,
	input  logic signed [ipe_pkg::INTERVAL_W-1:0]  interval,
	input  logic                                   last,
	output logic                                   result_valid,
	input  logic                                   result_stall,
	output logic signed [ipe_pkg::INTERVAL_W-1:0]  period,
	output logic [ipe_pkg::COUNT_OUT_W-1:0]        match_count,
	output logic                                   no_match,
	input  logic                                   cfg_we,
	input  logic [ipe_pkg::CFG_INDEX_W-1:0]        cfg_index,
	input  logic [ipe_pkg::CFG_DATA_W-1:0]         cfg_data
);
	import ipe_pkg::*;

	logic [TOLERANCE_W-1:0] tolerance_q;
	logic [MIN_START_W-1:0] minimum_start_q;
	qstat_t                 q_stat;
	entry_t                 push_entry;
	entry_t                 head_entry;
	logic                   q_push;
	logic                   q_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tolerance_q     <= TOLERANCE_RST;
			minimum_start_q <= MIN_START_RST;
		end else if (cfg_we) begin
			if (cfg_index == CFG_TOLERANCE) begin
				tolerance_q <= cfg_data[TOLERANCE_W-1:0];
			end else if (cfg_index == CFG_MIN_START) begin
				minimum_start_q <= cfg_data[MIN_START_W-1:0];
			end
		end
	end

	ipe_front #(
		.NUM_INTERVALS(NUM_INTERVALS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.interval     (interval),
		.last         (last),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.minimum_start(minimum_start_q),
		.q_stat       (q_stat),
		.q_push       (q_push),
		.q_entry      (push_entry)
	);

	ipe_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.wr_entry(push_entry),
		.pop     (q_pop),
		.rd_entry(head_entry),
		.stat    (q_stat)
	);

	ipe_back #(
		.NUM_INTERVALS(NUM_INTERVALS),
		.MAX_DIVISOR  (MAX_DIVISOR)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_entry     (head_entry),
		.q_stat      (q_stat),
		.q_pop       (q_pop),
		.tolerance   (tolerance_q),
		.period      (period),
		.match_count (match_count),
		.no_match    (no_match),
		.result_valid(result_valid),
		.result_stall(result_stall)
	);

	`IPE_ASSERT_IMPLIES(a_pop_not_empty, q_pop, !q_stat.empty, "pop from empty queue")
	`IPE_ASSERT_NEXT(a_push_fills, q_push && !q_pop, !q_stat.empty, "queue empty after push")
	`IPE_ASSERT_IMPLIES(a_no_match_zero, result_valid && no_match, period == '0 && match_count == '0, "no_match with nonzero result")
	`IPE_ASSERT_IMPLIES(a_match_counted, result_valid && !no_match, match_count != '0, "match result with zero count")

endmodule
